@@ sv/nacs_pkg.sv @@
// Package for the NUMA affinity CPU selector.
// Holds shared constants, register codes and the structs that run down the cell chain.
package nacs_pkg;

  localparam int NUM_CPUS_DEF  = 8;
  localparam int LOAD_BITS_DEF = 8;

  localparam int CPU_SLOTS = 8;   // CPUs covered by the register widths
  localparam int CPU_W     = 3;
  localparam int NODE_W    = 2;
  localparam int COUNT_W   = 4;
  localparam int LOADS_W   = 64;
  localparam int IN_W      = 80;
  localparam int OUT_W     = 8;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  typedef enum logic [1:0] {
    REG_NCPU     = 2'd0,
    REG_ONLINE   = 2'd1,
    REG_NODE_MAP = 2'd2,
    REG_BOOT_CPU = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CPU_SLOTS-1:0] allowed;
    logic                 use_pref;
    logic [NODE_W-1:0]    pref;
    logic [CPU_W-1:0]     home_cpu;
    logic [LOADS_W-1:0]   loads;
  } req_t;

  // pass a: node filtered when a preference applies; pass b: no node filter
  typedef struct packed {
    logic             have_a;
    logic [CPU_W-1:0] best_a;
    logic             have_b;
    logic [CPU_W-1:0] best_b;
  } pick_t;

  typedef struct packed {
    logic             relaxed;
    logic             found;
    logic [CPU_W-1:0] target;
  } res_t;

endpackage

@@ sv/nacs_cell.sv @@
// One CPU cell of the selector chain: compares its CPU's load against the running best.
// Depends on nacs_pkg.
module nacs_cell
  import nacs_pkg::*;
#(
  parameter int INDEX     = 0,
  parameter int LOAD_BITS = LOAD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [2*CPU_SLOTS-1:0] node_map,
  input  logic                 valid_in,
  output logic                 ready_in,
  input  req_t                 req_in,
  input  pick_t                pick_in,
  input  logic [LOAD_BITS-1:0] load_a_in,
  input  logic [LOAD_BITS-1:0] load_b_in,
  output logic                 valid,
  input  logic                 ready_out,
  output req_t                 req,
  output pick_t                pick,
  output logic [LOAD_BITS-1:0] load_a,
  output logic [LOAD_BITS-1:0] load_b
);

  localparam int LO = INDEX * LOAD_BITS;

  logic                 elig;
  logic                 node_hit;
  logic                 is_local;
  logic [LOAD_BITS-1:0] ld;
  logic                 elig_a;
  logic                 take_a;
  logic                 take_b;
  pick_t                pick_next;

  generate
    if (INDEX < CPU_SLOTS) begin : g_live
      assign elig     = req_in.allowed[INDEX];
      assign node_hit = node_map[NODE_W*INDEX +: NODE_W] == req_in.pref;
      assign is_local = req_in.home_cpu == CPU_W'(INDEX);
    end else begin : g_dead
      assign elig     = 1'b0;
      assign node_hit = 1'b0;
      assign is_local = 1'b0;
    end
    if (LO < LOADS_W) begin : g_load
      localparam int W = (LOADS_W - LO < LOAD_BITS) ? LOADS_W - LO : LOAD_BITS;
      assign ld = LOAD_BITS'(req_in.loads[LO +: W]);
    end else begin : g_noload
      assign ld = '0;
    end
  endgenerate

  assign elig_a = elig & (~req_in.use_pref | node_hit);
  assign take_a = elig_a & (~pick_in.have_a | (ld < load_a_in) |
                  ((ld == load_a_in) & is_local & (pick_in.best_a != req_in.home_cpu)));
  assign take_b = elig & (~pick_in.have_b | (ld < load_b_in) |
                  ((ld == load_b_in) & is_local & (pick_in.best_b != req_in.home_cpu)));

  always_comb begin
    pick_next = pick_in;
    if (take_a) begin
      pick_next.have_a = 1'b1;
      pick_next.best_a = CPU_W'(INDEX);
    end
    if (take_b) begin
      pick_next.have_b = 1'b1;
      pick_next.best_b = CPU_W'(INDEX);
    end
  end

  assign ready_in = ~valid | ready_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_in) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in) begin
      req    <= req_in;
      pick   <= pick_next;
      load_a <= take_a ? ld : load_a_in;
      load_b <= take_b ? ld : load_b_in;
    end
  end

endmodule

@@ sv/nacs_out.sv @@
// Result stage: turns the chain's picks into a result beat, with a skid register.
// Depends on nacs_pkg.
module nacs_out
  import nacs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [CPU_W-1:0] boot_cpu,
  input  logic             up_valid,
  output logic             up_ready,
  input  req_t             up_req,
  input  pick_t            up_pick,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // target[2:0], found[3], node_relaxed[4]
);

  res_t res;
  res_t out_res;
  res_t skid_res;
  logic skid_valid;
  logic up_acc;

  always_comb begin
    res.target  = boot_cpu;
    res.found   = 1'b0;
    res.relaxed = 1'b0;
    if (up_req.use_pref && up_pick.have_a) begin
      res.target = up_pick.best_a;
      res.found  = 1'b1;
    end else if (up_pick.have_b) begin
      res.target  = up_pick.best_b;
      res.found   = 1'b1;
      res.relaxed = up_req.use_pref;
    end
  end

  assign up_ready = ~skid_valid;
  assign up_acc   = up_valid & up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (~m_tvalid | m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= up_acc;
      end
    end else if (up_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (~m_tvalid | m_tready) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (up_acc) begin
      skid_res <= res;
    end
  end

  assign m_tdata = {{(OUT_W - $bits(res_t)){1'b0}}, out_res};

endmodule

@@ sv/numa_affinity_cpu_selector.sv @@
// Top level of the NUMA affinity CPU selector: config registers, cell chain, result stage.
// Depends on nacs_pkg, nacs_cell and nacs_out.
//
// Takes one request beat per cycle while the output is not stalled and returns one result
// beat per request, in order. Each request walks a row of NUM_CPUS cells, one CPU per cell,
// and is registered in every cell and then in the output register before its result beat
// goes valid; the row, the output register and the skid register hold up to NUM_CPUS + 2
// requests in flight.
// Throughput is one beat per cycle, set by the cell row advancing while it is not stalled.
// Registers are written through the APB port and must only change while no request
// is in flight.
module numa_affinity_cpu_selector
  import nacs_pkg::*;
#(
  parameter int NUM_CPUS  = NUM_CPUS_DEF,
  parameter int LOAD_BITS = LOAD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // affinity[7:0], use_preferred[8], preferred_node[10:9], requester[13:11],
  // cpu_loads[77:14], zeros above
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // target[2:0], found[3], node_relaxed[4], zeros above
  output logic [OUT_W-1:0]  m_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [COUNT_W-1:0]      ncpu;
  logic [CPU_SLOTS-1:0]    online_cfg;
  logic [2*CPU_SLOTS-1:0]  node_map;
  logic [CPU_W-1:0]        boot_cpu;
  logic                    wr_en;
  reg_idx_t                reg_idx;

  logic [CPU_SLOTS-1:0]    online;
  logic [CPU_SLOTS-1:0]    aff_online;
  req_t                    req_in;

  logic                    v    [NUM_CPUS+1];
  logic                    rdy  [NUM_CPUS+1];
  req_t                    r    [NUM_CPUS+1];
  pick_t                   p    [NUM_CPUS+1];
  logic [LOAD_BITS-1:0]    la   [NUM_CPUS+1];
  logic [LOAD_BITS-1:0]    lb   [NUM_CPUS+1];

  // config port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ncpu       <= COUNT_W'(1);
      online_cfg <= CPU_SLOTS'(1);
      node_map   <= '0;
      boot_cpu   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NCPU:     ncpu       <= pwdata[COUNT_W-1:0];
        REG_ONLINE:   online_cfg <= pwdata[CPU_SLOTS-1:0];
        REG_NODE_MAP: node_map   <= pwdata[2*CPU_SLOTS-1:0];
        REG_BOOT_CPU: boot_cpu   <= pwdata[CPU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_NCPU:     prdata = DATA_W'(ncpu);
      REG_ONLINE:   prdata = DATA_W'(online_cfg);
      REG_NODE_MAP: prdata = DATA_W'(node_map);
      REG_BOOT_CPU: prdata = DATA_W'(boot_cpu);
      default:      prdata = '0;
    endcase
  end

  // allowed set of the incoming beat
  always_comb begin
    for (int i = 0; i < CPU_SLOTS; i++) begin
      online[i] = online_cfg[i] && (COUNT_W'(i) < ncpu) && (i < NUM_CPUS);
    end
  end

  assign aff_online = s_tdata[7:0] & online;

  always_comb begin
    req_in.allowed  = (aff_online == '0) ? online : aff_online;
    req_in.use_pref = s_tdata[8];
    req_in.pref     = s_tdata[10:9];
    req_in.home_cpu = s_tdata[13:11];
    req_in.loads    = s_tdata[77:14];
  end

  assign v[0]   = s_tvalid;
  assign r[0]   = req_in;
  assign p[0]   = '0;
  assign la[0]  = '0;
  assign lb[0]  = '0;
  assign s_tready = rdy[0];

  generate
    for (genvar g = 0; g < NUM_CPUS; g++) begin : g_cell
      nacs_cell #(
        .INDEX     (g),
        .LOAD_BITS (LOAD_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .node_map  (node_map),
        .valid_in  (v[g]),
        .ready_in  (rdy[g]),
        .req_in    (r[g]),
        .pick_in   (p[g]),
        .load_a_in (la[g]),
        .load_b_in (lb[g]),
        .valid     (v[g+1]),
        .ready_out (rdy[g+1]),
        .req       (r[g+1]),
        .pick      (p[g+1]),
        .load_a    (la[g+1]),
        .load_b    (lb[g+1])
      );
    end
  endgenerate

  nacs_out u_out (
    .clk      (clk),
    .rst      (rst),
    .boot_cpu (boot_cpu),
    .up_valid (v[NUM_CPUS]),
    .up_ready (rdy[NUM_CPUS]),
    .up_req   (r[NUM_CPUS]),
    .up_pick  (p[NUM_CPUS]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_found_online: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> online_cfg[m_tdata[2:0]])
    else $error("selected CPU is offline");

  a_found_configured: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> ({1'b0, m_tdata[2:0]} < ncpu))
    else $error("selected CPU beyond configured count");

  a_relaxed_found: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[4]) |-> m_tdata[3])
    else $error("node_relaxed without found");

  a_boot_fallback: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[3]) |-> (m_tdata[2:0] == boot_cpu))
    else $error("fallback target is not boot_cpu");

endmodule
